### src/capsule_sphere_collision_defines.svh
// Assertion macros shared by the capsule-sphere collision RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CAPSULE_SPHERE_COLLISION_DEFINES_SVH
`define CAPSULE_SPHERE_COLLISION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/csc_pkg.sv
// Shared widths, constants and word types of the capsule-sphere collision pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package csc_pkg;

    localparam int CoordW = 24;
    localparam int RadW   = CoordW - 1;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int SumW   = ProdW + 2;
    localparam int TFrac  = 24;
    localparam int TW     = TFrac + 1;
    localparam int DtW    = DiffW + TW + 1;
    localparam int SclW   = DtW + 1;
    localparam int OffW   = DiffW + 2;
    localparam int SqfW   = 2 * OffW;
    localparam int SumDW  = SqfW + 2;
    localparam int RsumW  = CoordW;
    localparam int RsqW   = 2 * RsumW;
    localparam int SqW    = RsqW;
    localparam int SqrtSteps = SqW / 2;
    localparam int DistW  = SqrtSteps + 1;
    localparam int QSteps = 15;
    localparam int NumW   = DistW + QSteps + 1;
    localparam int PushW  = 16;
    localparam int DepthW = 24;
    localparam int Unit   = 16384;

    localparam logic [TW-1:0] TOne = TW'(1) << TFrac;

    typedef logic signed [DiffW-1:0] diff_t;
    typedef diff_t [2:0] diff3_t;
    typedef logic signed [OffW-1:0] off_t;
    typedef off_t [2:0] off3_t;
    typedef logic signed [PushW-1:0] push_t;
    typedef push_t [2:0] push3_t;

    typedef enum logic [1:0] {
        TK_ZERO,
        TK_ONE,
        TK_DIV
    } tkind_t;

    typedef struct packed {
        diff3_t            d;
        diff3_t            e;
        logic [RsumW-1:0]  rsum;
        logic [RsqW-1:0]   rsq;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [SumW-1:0]         lensq;
        logic signed [SumW-1:0]  dot;
    } front_t;

    typedef struct packed {
        off3_t             off;
        logic [RsumW-1:0]  rsum;
        logic              hit;
        logic [SqW-1:0]    distsq;
    } geo_t;

    typedef struct packed {
        off3_t             off;
        logic [RsumW-1:0]  rsum;
        logic              hit;
        logic [DistW-1:0]  distance;
    } rad_t;

    typedef struct packed {
        logic               hit;
        push3_t             push;
        logic [DepthW-1:0]  depth;
    } res_t;

endpackage

### src/csc_front.sv
// Front stages: segment and center differences, their products, the sums that give
// the squared length and the projection dot product, and the squared radius sum.
`timescale 1ns / 1ps

module csc_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  logic                              in_valid,
    input  logic signed [csc_pkg::CoordW-1:0] p0 [0:2],
    input  logic signed [csc_pkg::CoordW-1:0] p1 [0:2],
    input  logic signed [csc_pkg::CoordW-1:0] cen [0:2],
    input  logic [csc_pkg::RadW-1:0]          rad_c,
    input  logic [csc_pkg::RadW-1:0]          rad_s,
    output logic                              out_valid,
    output csc_pkg::front_t                   out_word
);

    logic                             a_valid_reg, b_valid_reg, c_valid_reg;
    csc_pkg::diff_t                   a_d_reg [0:2];
    csc_pkg::diff_t                   a_e_reg [0:2];
    csc_pkg::diff_t                   a_d_next [0:2];
    csc_pkg::diff_t                   a_e_next [0:2];
    logic [csc_pkg::RsumW-1:0]        a_rsum_reg, a_rsum_next;
    logic signed [csc_pkg::ProdW-1:0] b_dd_reg [0:2];
    logic signed [csc_pkg::ProdW-1:0] b_de_reg [0:2];
    logic signed [csc_pkg::ProdW-1:0] b_dd_next [0:2];
    logic signed [csc_pkg::ProdW-1:0] b_de_next [0:2];
    csc_pkg::diff3_t                  b_d_reg, b_e_reg;
    logic [csc_pkg::RsumW-1:0]        b_rsum_reg;
    logic [csc_pkg::RsqW-1:0]         b_rsq_reg, b_rsq_next;
    csc_pkg::front_t                  c_word_reg, c_word_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_d_next[i] = csc_pkg::DiffW'(p1[i]) - csc_pkg::DiffW'(p0[i]);
            a_e_next[i] = csc_pkg::DiffW'(cen[i]) - csc_pkg::DiffW'(p0[i]);
        end
        a_rsum_next = csc_pkg::RsumW'(rad_c) + csc_pkg::RsumW'(rad_s);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_dd_next[i] = a_d_reg[i] * a_d_reg[i];
            b_de_next[i] = a_d_reg[i] * a_e_reg[i];
        end
        b_rsq_next = a_rsum_reg * a_rsum_reg;
    end

    always_comb
    begin
        c_word_next.side.d    = b_d_reg;
        c_word_next.side.e    = b_e_reg;
        c_word_next.side.rsum = b_rsum_reg;
        c_word_next.side.rsq  = b_rsq_reg;
        c_word_next.lensq = csc_pkg::SumW'(b_dd_reg[0]) + csc_pkg::SumW'(b_dd_reg[1])
                          + csc_pkg::SumW'(b_dd_reg[2]);
        c_word_next.dot   = csc_pkg::SumW'(b_de_reg[0]) + csc_pkg::SumW'(b_de_reg[1])
                          + csc_pkg::SumW'(b_de_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_d_reg[i]  <= a_d_next[i];
                a_e_reg[i]  <= a_e_next[i];
                b_dd_reg[i] <= b_dd_next[i];
                b_de_reg[i] <= b_de_next[i];
                b_d_reg[i]  <= a_d_reg[i];
                b_e_reg[i]  <= a_e_reg[i];
            end
            a_rsum_reg <= a_rsum_next;
            b_rsum_reg <= a_rsum_reg;
            b_rsq_reg  <= b_rsq_next;
            c_word_reg <= c_word_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_word  = c_word_reg;

endmodule

### src/csc_tdiv.sv
// Projection parameter: clamps t to [0,1] and runs a restoring fractional divider,
// one quotient bit per stage. Uses csc_pkg.
`timescale 1ns / 1ps

module csc_tdiv
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       ce,
    input  logic                       in_valid,
    input  csc_pkg::front_t            in_word,
    output logic                       out_valid,
    output logic [csc_pkg::TW-1:0]     t,
    output csc_pkg::side_t             side
);

    localparam int N = csc_pkg::TFrac;

    logic                       v_reg    [0:N];
    logic [csc_pkg::SumW-1:0]   rem_reg  [0:N];
    logic [csc_pkg::SumW-1:0]   den_reg  [0:N];
    logic [N-1:0]               q_reg    [0:N];
    csc_pkg::tkind_t            kind_reg [0:N];
    csc_pkg::side_t             side_reg [0:N];
    csc_pkg::tkind_t            kind_next;
    logic                       out_v_reg;
    logic [csc_pkg::TW-1:0]     t_reg, t_next;
    csc_pkg::side_t             side_out_reg;

    always_comb
    begin
        if (in_word.lensq == '0 || $signed(in_word.dot) <= 0)
            kind_next = csc_pkg::TK_ZERO;
        else if ($unsigned(in_word.dot) >= in_word.lensq)
            kind_next = csc_pkg::TK_ONE;
        else
            kind_next = csc_pkg::TK_DIV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
                v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
                v_reg[k] <= v_reg[k-1];
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            kind_reg[0] <= kind_next;
            rem_reg[0]  <= (kind_next == csc_pkg::TK_DIV) ? $unsigned(in_word.dot) : '0;
            den_reg[0]  <= in_word.lensq;
            q_reg[0]    <= '0;
            side_reg[0] <= in_word.side;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [csc_pkg::SumW-1:0] sh, rem_next;
        logic                     ge;

        always_comb
        begin
            sh       = rem_reg[k-1] << 1;
            ge       = (sh >= den_reg[k-1]);
            rem_next = ge ? sh - den_reg[k-1] : sh;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][N-2:0], ge};
                kind_reg[k] <= kind_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb
    begin
        case (kind_reg[N])
            csc_pkg::TK_ONE: t_next = csc_pkg::TOne;
            csc_pkg::TK_DIV: t_next = csc_pkg::TW'(q_reg[N]);
            default:         t_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t_reg        <= t_next;
            side_out_reg <= side_reg[N];
        end
    end

    assign out_valid = out_v_reg;
    assign t         = t_reg;
    assign side      = side_out_reg;

endmodule

### src/csc_offset.sv
// Closest-point offset: scales the segment by t, rounds the offset to Q12.12,
// squares and sums it and compares against the squared radius sum. Uses csc_pkg.
`timescale 1ns / 1ps

module csc_offset
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic [csc_pkg::TW-1:0]  t,
    input  csc_pkg::side_t          side,
    output logic                    out_valid,
    output csc_pkg::geo_t           out_word
);

    logic                              a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic signed [csc_pkg::DtW-1:0]    a_dt_reg [0:2];
    logic signed [csc_pkg::DtW-1:0]    a_dt_next [0:2];
    csc_pkg::diff3_t                   a_e_reg;
    logic [csc_pkg::RsumW-1:0]         a_rsum_reg, b_rsum_reg, c_rsum_reg;
    logic [csc_pkg::RsqW-1:0]          a_rsq_reg, b_rsq_reg, c_rsq_reg;
    csc_pkg::off_t                     b_off_reg [0:2];
    csc_pkg::off_t                     b_off_next [0:2];
    logic signed [csc_pkg::SclW-1:0]   scaled [0:2];
    logic [csc_pkg::SclW-1:0]          mag [0:2];
    logic signed [csc_pkg::SqfW-1:0]   c_sq_reg [0:2];
    logic signed [csc_pkg::SqfW-1:0]   c_sq_next [0:2];
    csc_pkg::off3_t                    c_off_reg;
    logic [csc_pkg::SumDW-1:0]         distsq_full;
    csc_pkg::geo_t                     d_word_reg, d_word_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            a_dt_next[i] = $signed(side.d[i]) * $signed({1'b0, t});
    end

    // Offset rounds half away from zero back to Q12.12.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled[i] = (csc_pkg::SclW'($signed(a_e_reg[i])) <<< csc_pkg::TFrac)
                      - csc_pkg::SclW'(a_dt_reg[i]);
            mag[i] = scaled[i][csc_pkg::SclW-1] ? $unsigned(-scaled[i]) : $unsigned(scaled[i]);
            mag[i] = (mag[i] + (csc_pkg::SclW'(1) << (csc_pkg::TFrac - 1))) >> csc_pkg::TFrac;
            b_off_next[i] = scaled[i][csc_pkg::SclW-1] ? -csc_pkg::OffW'(mag[i])
                                                       : csc_pkg::OffW'(mag[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c_sq_next[i] = b_off_reg[i] * b_off_reg[i];
    end

    always_comb
    begin
        distsq_full = csc_pkg::SumDW'($unsigned(c_sq_reg[0]))
                    + csc_pkg::SumDW'($unsigned(c_sq_reg[1]))
                    + csc_pkg::SumDW'($unsigned(c_sq_reg[2]));
        d_word_next.off    = c_off_reg;
        d_word_next.rsum   = c_rsum_reg;
        d_word_next.hit    = (distsq_full < csc_pkg::SumDW'(c_rsq_reg));
        d_word_next.distsq = distsq_full[csc_pkg::SqW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_dt_reg[i]  <= a_dt_next[i];
                b_off_reg[i] <= b_off_next[i];
                c_sq_reg[i]  <= c_sq_next[i];
                c_off_reg[i] <= b_off_reg[i];
            end
            a_e_reg    <= side.e;
            a_rsum_reg <= side.rsum;
            a_rsq_reg  <= side.rsq;
            b_rsum_reg <= a_rsum_reg;
            b_rsq_reg  <= a_rsq_reg;
            c_rsum_reg <= b_rsum_reg;
            c_rsq_reg  <= b_rsq_reg;
            d_word_reg <= d_word_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_word  = d_word_reg;

endmodule

### src/csc_sqrt.sv
// Pipelined digit-by-digit square root of the squared distance, one result bit per
// stage, with a final round-to-nearest stage. Uses csc_pkg.
`timescale 1ns / 1ps

module csc_sqrt
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  csc_pkg::geo_t  in_word,
    output logic           out_valid,
    output csc_pkg::rad_t  out_word
);

    localparam int N = csc_pkg::SqrtSteps;

    logic                       v_reg    [0:N];
    logic [csc_pkg::SqW-1:0]    x_reg    [0:N];
    logic [csc_pkg::SqW-1:0]    r_reg    [0:N];
    csc_pkg::off3_t             off_reg  [0:N];
    logic [csc_pkg::RsumW-1:0]  rsum_reg [0:N];
    logic                       hit_reg  [0:N];
    logic                       out_v_reg;
    csc_pkg::rad_t              word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
                v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
                v_reg[k] <= v_reg[k-1];
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]    <= in_word.distsq;
            r_reg[0]    <= '0;
            off_reg[0]  <= in_word.off;
            rsum_reg[0] <= in_word.rsum;
            hit_reg[0]  <= in_word.hit;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        localparam logic [csc_pkg::SqW-1:0] Bit = csc_pkg::SqW'(1) << (csc_pkg::SqW - 2 * k);
        logic [csc_pkg::SqW:0]   rb;
        logic                    ge;
        logic [csc_pkg::SqW-1:0] x_next, r_next;

        always_comb
        begin
            rb     = {1'b0, r_reg[k-1]} + {1'b0, Bit};
            ge     = ({1'b0, x_reg[k-1]} >= rb);
            x_next = ge ? x_reg[k-1] - rb[csc_pkg::SqW-1:0] : x_reg[k-1];
            r_next = ge ? (r_reg[k-1] >> 1) + Bit : r_reg[k-1] >> 1;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                x_reg[k]    <= x_next;
                r_reg[k]    <= r_next;
                off_reg[k]  <= off_reg[k-1];
                rsum_reg[k] <= rsum_reg[k-1];
                hit_reg[k]  <= hit_reg[k-1];
            end
        end
    end

    // The final remainder equals n - r*r, so rounding needs no multiply.
    always_comb
    begin
        word_next.off      = off_reg[N];
        word_next.rsum     = rsum_reg[N];
        word_next.hit      = hit_reg[N];
        word_next.distance = csc_pkg::DistW'(r_reg[N])
                           + csc_pkg::DistW'(x_reg[N] > r_reg[N]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            word_reg <= word_next;
    end

    assign out_valid = out_v_reg;
    assign out_word  = word_reg;

endmodule

### src/csc_norm.sv
// Direction normalization: three pipelined restoring dividers give offset/distance
// in Q1.14, then the depth and the miss gating form the result word. Uses csc_pkg.
`timescale 1ns / 1ps

module csc_norm
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  csc_pkg::rad_t  in_word,
    output logic           out_valid,
    output csc_pkg::res_t  out_word
);

    localparam int N = csc_pkg::QSteps;

    logic                       v_reg    [0:N];
    logic [csc_pkg::NumW-1:0]   rem_reg  [0:N][0:2];
    logic [N-1:0]               q_reg    [0:N][0:2];
    logic [2:0]                 neg_reg  [0:N];
    logic [csc_pkg::DistW-1:0]  dist_reg [0:N];
    logic [csc_pkg::RsumW-1:0]  rsum_reg [0:N];
    logic                       hit_reg  [0:N];
    logic [csc_pkg::OffW-1:0]   mag0 [0:2];
    logic [2:0]                 neg0;
    logic                       out_v_reg;
    csc_pkg::res_t              word_reg, word_next;
    logic [N-1:0]               qv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg0[i] = in_word.off[i][csc_pkg::OffW-1];
            mag0[i] = neg0[i] ? $unsigned(-in_word.off[i]) : $unsigned(in_word.off[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
                v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
                v_reg[k] <= v_reg[k-1];
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= (csc_pkg::NumW'(mag0[i]) << 14)
                               + csc_pkg::NumW'(in_word.distance >> 1);
                q_reg[0][i]   <= '0;
            end
            neg_reg[0]  <= neg0;
            dist_reg[0] <= in_word.distance;
            rsum_reg[0] <= in_word.rsum;
            hit_reg[0]  <= in_word.hit;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [csc_pkg::NumW-1:0] dsh;
        logic [2:0]               ge;
        logic [csc_pkg::NumW-1:0] rem_next [0:2];

        always_comb
        begin
            dsh = csc_pkg::NumW'(dist_reg[k-1]) << (N - k);
            for (int i = 0; i < 3; i++)
            begin
                ge[i]       = (rem_reg[k-1][i] >= dsh);
                rem_next[i] = ge[i] ? rem_reg[k-1][i] - dsh : rem_reg[k-1][i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i] <= rem_next[i];
                    q_reg[k][i]   <= {q_reg[k-1][i][N-2:0], ge[i]};
                end
                neg_reg[k]  <= neg_reg[k-1];
                dist_reg[k] <= dist_reg[k-1];
                rsum_reg[k] <= rsum_reg[k-1];
                hit_reg[k]  <= hit_reg[k-1];
            end
        end
    end

    always_comb
    begin
        qv = '0;
        word_next.hit   = hit_reg[N];
        word_next.depth = '0;
        for (int i = 0; i < 3; i++)
        begin
            qv = (q_reg[N][i] > N'(csc_pkg::Unit)) ? N'(csc_pkg::Unit) : q_reg[N][i];
            if (!hit_reg[N] || dist_reg[N] == '0)
                word_next.push[i] = '0;
            else if (neg_reg[N][i])
                word_next.push[i] = -csc_pkg::PushW'(qv);
            else
                word_next.push[i] = csc_pkg::PushW'(qv);
        end
        if (hit_reg[N] && csc_pkg::DistW'(rsum_reg[N]) > dist_reg[N])
            word_next.depth = csc_pkg::DepthW'(csc_pkg::DistW'(rsum_reg[N]) - dist_reg[N]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            word_reg <= word_next;
    end

    assign out_valid = out_v_reg;
    assign out_word  = word_reg;

endmodule

### src/capsule_sphere_collision.sv
// Capsule-sphere overlap test: one query word in, one result word out, fully
// pipelined. A word can enter every clock cycle while the output is not held; the
// depth of the pipeline is set by the one-bit-per-stage projection divider (24 steps),
// square root (24 steps) and direction dividers (15 steps). When the output word is
// held by the consumer the whole pipeline freezes and s_axis_tready drops.
`timescale 1ns / 1ps
`include "capsule_sphere_collision_defines.svh"

module capsule_sphere_collision
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    // capsule_radius, sphere_x, sphere_y, sphere_z, sphere_radius, zero pad
    input  logic [263:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, push_x, push_y, push_z, depth, zero pad
    output logic [79:0]  m_axis_tdata
);

    logic                              ce;
    logic signed [csc_pkg::CoordW-1:0] p0 [0:2];
    logic signed [csc_pkg::CoordW-1:0] p1 [0:2];
    logic signed [csc_pkg::CoordW-1:0] cen [0:2];
    logic [csc_pkg::RadW-1:0]          rad_c, rad_s;
    logic                              front_valid, tdiv_valid, geo_valid, rad_valid;
    csc_pkg::front_t                   front_word;
    logic [csc_pkg::TW-1:0]            t_val;
    csc_pkg::side_t                    side_word;
    csc_pkg::geo_t                     geo_word;
    csc_pkg::rad_t                     rad_word;
    csc_pkg::res_t                     res_word;

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    assign p0[0]  = s_axis_tdata[23:0];
    assign p0[1]  = s_axis_tdata[47:24];
    assign p0[2]  = s_axis_tdata[71:48];
    assign p1[0]  = s_axis_tdata[95:72];
    assign p1[1]  = s_axis_tdata[119:96];
    assign p1[2]  = s_axis_tdata[143:120];
    assign rad_c  = s_axis_tdata[166:144];
    assign cen[0] = s_axis_tdata[190:167];
    assign cen[1] = s_axis_tdata[214:191];
    assign cen[2] = s_axis_tdata[238:215];
    assign rad_s  = s_axis_tdata[261:239];

    csc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .p0        (p0),
        .p1        (p1),
        .cen       (cen),
        .rad_c     (rad_c),
        .rad_s     (rad_s),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    csc_tdiv u_tdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (front_valid),
        .in_word   (front_word),
        .out_valid (tdiv_valid),
        .t         (t_val),
        .side      (side_word)
    );

    csc_offset u_offset
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (tdiv_valid),
        .t         (t_val),
        .side      (side_word),
        .out_valid (geo_valid),
        .out_word  (geo_word)
    );

    csc_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (geo_valid),
        .in_word   (geo_word),
        .out_valid (rad_valid),
        .out_word  (rad_word)
    );

    csc_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (rad_valid),
        .in_word   (rad_word),
        .out_valid (m_axis_tvalid),
        .out_word  (res_word)
    );

    assign m_axis_tdata = {7'b0, res_word.depth, res_word.push[2], res_word.push[1],
                           res_word.push[0], res_word.hit};

    `CSC_ASSERT_IMPLY(a_ready_follows_stall, clk, rst_n, 1'b1,
        s_axis_tready == (!m_axis_tvalid || m_axis_tready),
        "input ready does not follow the output stall")
    `CSC_ASSERT_IMPLY(a_miss_is_zero, clk, rst_n, m_axis_tvalid && !res_word.hit,
        res_word.push == '0 && res_word.depth == '0,
        "a missed query carries a nonzero direction or depth")
    `CSC_ASSERT_IMPLY(a_push_range, clk, rst_n, m_axis_tvalid,
        $signed(res_word.push[0]) <= 16384 && $signed(res_word.push[0]) >= -16384
        && $signed(res_word.push[1]) <= 16384 && $signed(res_word.push[1]) >= -16384
        && $signed(res_word.push[2]) <= 16384 && $signed(res_word.push[2]) >= -16384,
        "direction component exceeds unit magnitude")
    `CSC_ASSERT_NEXT(a_stall_freezes_front, clk, rst_n, !s_axis_tready,
        $stable(front_word) && $stable(front_valid),
        "front stage moved while the pipeline was stalled")

endmodule

### verif/tb_top.sv
// Self-checking testbench for the capsule-sphere collision pipeline: directed and random
// queries, a built-in fixed-point predictor and a scoreboard class.
// Depends on csc_pkg and capsule_sphere_collision.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic hit;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [23:0] depth;
    } overlap_t;

    localparam longint DLimit = (64'sd1 <<< 30) - 1;

    function automatic longint clip30(longint v);
        if (v > DLimit) return DLimit;
        if (v < -DLimit) return -DLimit;
        return v;
    endfunction

    function automatic longint round_off(longint v);
        longint half;
        half = 64'sd1 <<< 23;
        if (v >= 0) return (v + half) >>> 24;
        return -((-v + half) >>> 24);
    endfunction

    function automatic longint unsigned root_nearest(longint unsigned n);
        longint unsigned r, b, x;
        r = 0;
        b = 64'd1 << 62;
        x = n;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (n - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic logic signed [15:0] unit_comp(longint o, longint unsigned dist_val);
        longint unsigned m, q;
        m = (o < 0) ? -o : o;
        q = ((m << 14) + (dist_val >> 1)) / dist_val;
        if (q > csc_pkg::Unit) q = csc_pkg::Unit;
        return (o < 0) ? -16'(q) : 16'(q);
    endfunction

    function automatic overlap_t predict_overlap(logic [263:0] w);
        longint p0[3], p1[3], c[3], d[3], e[3], off[3];
        longint dot, sc;
        longint unsigned lensq, distsq, rsum, t, dist_val, dep, rem, q;
        overlap_t r;
        dot = 0;
        lensq = 0;
        distsq = 0;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            p0[i] = longint'($signed(w[24*i +: 24]));
            p1[i] = longint'($signed(w[72 + 24*i +: 24]));
            c[i] = longint'($signed(w[167 + 24*i +: 24]));
            d[i] = clip30(p1[i] - p0[i]);
            e[i] = clip30(c[i] - p0[i]);
            lensq += d[i] * d[i];
            dot += d[i] * e[i];
        end
        rsum = longint'(w[144 +: 23]) + longint'(w[239 +: 23]);
        if (lensq == 0 || dot <= 0) t = 0;
        else if (longint'(dot) >= lensq) t = 64'd1 << 24;
        else
        begin
            q = 0;
            rem = dot;
            for (int i = 0; i < 24; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= lensq)
                begin
                    rem = rem - lensq;
                    q = q | 1;
                end
            end
            t = q;
        end
        for (int i = 0; i < 3; i++)
        begin
            sc = e[i] * (64'sd1 <<< 24) - d[i] * longint'(t);
            off[i] = clip30(round_off(sc));
            distsq += off[i] * off[i];
        end
        if (distsq >= rsum * rsum) return r;
        dist_val = root_nearest(distsq);
        r.hit = 1'b1;
        if (dist_val > 0)
        begin
            r.px = unit_comp(off[0], dist_val);
            r.py = unit_comp(off[1], dist_val);
            r.pz = unit_comp(off[2], dist_val);
        end
        dep = (rsum > dist_val) ? rsum - dist_val : 0;
        if (dep > 64'hFFFFFF) dep = 64'hFFFFFF;
        r.depth = dep[23:0];
        return r;
    endfunction

    class overlap_board;
        overlap_t pending[$];
        int errors = 0;
        int hits = 0;
        int checked = 0;

        function void note_query(logic [263:0] w);
            pending.push_back(predict_overlap(w));
        endfunction

        function void check_result(logic [79:0] w);
            overlap_t got, exp;
            got.hit = w[0];
            got.px = w[16:1];
            got.py = w[32:17];
            got.pz = w[48:33];
            got.depth = w[72:49];
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, w);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (exp.hit) hits++;
            if (got.hit !== exp.hit)
            begin
                $display("%0t: hit expected %0d actual %0d", $time, exp.hit, got.hit);
                errors++;
            end
            if (got.px !== exp.px)
            begin
                $display("%0t: push_x expected %0d actual %0d", $time, exp.px, got.px);
                errors++;
            end
            if (got.py !== exp.py)
            begin
                $display("%0t: push_y expected %0d actual %0d", $time, exp.py, got.py);
                errors++;
            end
            if (got.pz !== exp.pz)
            begin
                $display("%0t: push_z expected %0d actual %0d", $time, exp.pz, got.pz);
                errors++;
            end
            if (got.depth !== exp.depth)
            begin
                $display("%0t: depth expected %0d actual %0d", $time, exp.depth,
                    got.depth);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    overlap_board board = new();
    bit stim_done = 0;
    bit hold_sink = 0;

    always #4 clk = ~clk;

    capsule_sphere_collision DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [263:0] pack_query(logic [23:0] s[3], logic [23:0] en[3],
        logic [22:0] cr, logic [23:0] sp[3], logic [22:0] sr);
        logic [263:0] w;
        w = '0;
        for (int i = 0; i < 3; i++)
        begin
            w[24*i +: 24] = s[i];
            w[72 + 24*i +: 24] = en[i];
            w[167 + 24*i +: 24] = sp[i];
        end
        w[144 +: 23] = cr;
        w[239 +: 23] = sr;
        return w;
    endfunction

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom());
            1: return 24'($signed($urandom_range(0, 40960)) - 20480);
            default: return 24'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_query(logic [263:0] w, bit gaps);
        int idle;
        idle = gaps ? $urandom_range(0, 11) : 0;
        if (idle != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_axis_tdata <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_query(w);
        @(negedge clk);
    endtask

    task automatic send_random(bit gaps);
        logic [23:0] s[3], en[3], sp[3];
        logic [22:0] cr, sr;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 6 ? 1 : 2);
        for (int i = 0; i < 3; i++)
        begin
            s[i] = rand_coord(mode);
            en[i] = ($urandom_range(0, 15) == 0) ? s[i] : rand_coord(mode);
            sp[i] = ($urandom_range(0, 15) == 0) ? s[i] : rand_coord(mode);
        end
        if (mode == 0)
        begin
            cr = 23'($urandom());
            sr = 23'($urandom());
        end
        else
        begin
            cr = 23'($urandom_range(0, mode == 1 ? 16384 : 1200));
            sr = 23'($urandom_range(0, mode == 1 ? 16384 : 1200));
        end
        send_query(pack_query(s, en, cr, sp, sr), gaps);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        logic [23:0] a[3], b[3], c[3];
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        a = '{24'h800000, 24'h800000, 24'h800000};
        b = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
        send_query(pack_query(a, b, 23'h7FFFFF, b, 23'h7FFFFF), 0);
        send_query(pack_query(b, a, 23'h7FFFFF, a, 23'h7FFFFF), 0);
        send_query(pack_query(a, b, 23'h0, a, 23'h0), 0);
        c = '{24'd0, 24'd0, 24'd0};
        send_query(pack_query(c, c, 23'd4096, c, 23'd4096), 0);
        send_query(pack_query(c, c, 23'd0, c, 23'd0), 0);
        send_query(pack_query(c, c, 23'd4096, '{24'd8192, 24'd0, 24'd0}, 23'd4096), 0);
        send_query(pack_query(c, c, 23'd4096, '{24'd8191, 24'd0, 24'd0}, 23'd4096), 0);
        send_query(pack_query(c, c, 23'd4096, '{24'd8190, 24'd0, 24'd0}, 23'd4096), 0);
        send_query(pack_query(c, '{24'd40960, 24'd0, 24'd0}, 23'd2048,
            '{24'd20480, 24'd4096, 24'd0}, 23'd4096), 0);
        send_query(pack_query(c, '{24'd40960, 24'd0, 24'd0}, 23'd2048,
            '{-24'sd4096, 24'd1000, 24'd0}, 23'd4096), 0);
        send_query(pack_query(c, '{24'd40960, 24'd0, 24'd0}, 23'd2048,
            '{24'd45000, -24'sd1000, 24'd500}, 23'd4096), 0);
        send_query(pack_query(c, '{24'd40960, 24'd0, 24'd0}, 23'd2048,
            '{24'd10000, 24'd0, 24'd0}, 23'd4096), 0);
        send_query(pack_query(b, b, 23'h7FFFFF, b, 23'h7FFFFF), 0);
        send_query(pack_query(a, a, 23'h555555, a, 23'h2AAAAA), 0);
        send_query(pack_query('{24'h555555, 24'hAAAAAA, 24'h555555},
            '{24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 23'h2AAAAA,
            '{24'h000FFF, 24'hFFF000, 24'h0F0F0F}, 23'h555555), 0);
        for (int i = 0; i < 900; i++) send_random(i % 200 >= 100);
        wait_drained();
        repeat (20) send_random(1);
        hold_sink = 1;
        for (int i = 0; i < 150; i++) send_random(0);
        hold_sink = 0;
        for (int i = 0; i < 930; i++) send_random(i % 150 >= 60);
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        int idle;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (idle != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle - 1) @(negedge clk);
                @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    initial
    begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Checked %0d results (%0d hits), including extremes, stalls and drains.",
            board.checked, board.hits);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("capsule_sphere_collision test passed");
        else
            $display("capsule_sphere_collision test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("capsule_sphere_collision test failed");
        $finish;
    end
endmodule
